>>> sv/lfu_pkg.sv
`timescale 1ns / 1ps

package lfu_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned COUNT_BITS = 16;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CAP_W   = 5;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  localparam logic [CAP_W-1:0]      CAP_RESET  = CAP_W'(16);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_INIT = COUNT_BITS'(1);
  localparam logic [IDX_W-1:0]      LAST_IDX   = IDX_W'(ENTRIES - 1);

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [VALUE_W-1:0]    value;
    logic [COUNT_BITS-1:0] count;
    logic [STAMP_W-1:0]    stamp;
  } entry_t;

  typedef struct packed {
    logic                  found;
    logic [IDX_W-1:0]      match_idx;
    logic [VALUE_W-1:0]    match_value;
    logic [COUNT_BITS-1:0] match_count;
    logic                  have_free;
    logic [IDX_W-1:0]      free_idx;
    logic                  have_victim;
    logic [IDX_W-1:0]      victim_idx;
    logic [KEY_W-1:0]      victim_key;
  } scan_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE
  } state_e;

endpackage

>>> sv/lfu_ram.sv
`timescale 1ns / 1ps

module lfu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/lfu_scan.sv
`timescale 1ns / 1ps

module lfu_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clr_i,
  input  logic                          issue_i,
  input  logic [lfu_pkg::IDX_W-1:0]     issue_idx_i,
  input  logic [lfu_pkg::ENTRIES-1:0]   valid_bits_i,
  input  lfu_pkg::entry_t               rd_data_i,
  input  logic [lfu_pkg::KEY_W-1:0]     key_i,
  input  logic [lfu_pkg::STAMP_W-1:0]   stamp_i,
  output lfu_pkg::scan_res_t            res_o
);

  logic                              beat_q;
  logic [lfu_pkg::IDX_W-1:0]         beat_idx_q;
  logic                              found_q;
  logic                              have_free_q;
  logic                              have_vic_q;
  logic [lfu_pkg::IDX_W-1:0]         match_idx_q;
  logic [lfu_pkg::VALUE_W-1:0]       match_value_q;
  logic [lfu_pkg::COUNT_BITS-1:0]    match_count_q;
  logic [lfu_pkg::IDX_W-1:0]         free_idx_q;
  logic [lfu_pkg::IDX_W-1:0]         vic_idx_q;
  logic [lfu_pkg::KEY_W-1:0]         vic_key_q;
  logic [lfu_pkg::COUNT_BITS-1:0]    vic_count_q;
  logic [lfu_pkg::STAMP_W-1:0]       vic_age_q;
  logic                              entry_ok;
  logic [lfu_pkg::STAMP_W-1:0]       age;
  logic                              take_match;
  logic                              take_free;
  logic                              take_vic;

  assign entry_ok = valid_bits_i[beat_idx_q];
  assign age      = stamp_i - rd_data_i.stamp;

  assign take_match = beat_q && entry_ok && !found_q && (rd_data_i.key == key_i);
  assign take_free  = beat_q && !entry_ok && !have_free_q;
  assign take_vic   = beat_q && entry_ok &&
                      (!have_vic_q || (rd_data_i.count < vic_count_q) ||
                       ((rd_data_i.count == vic_count_q) && (age > vic_age_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= 1'b0;
      found_q     <= 1'b0;
      have_free_q <= 1'b0;
      have_vic_q  <= 1'b0;
    end else begin
      beat_q <= issue_i;
      if (clr_i) begin
        found_q     <= 1'b0;
        have_free_q <= 1'b0;
        have_vic_q  <= 1'b0;
      end else begin
        found_q     <= found_q | take_match;
        have_free_q <= have_free_q | take_free;
        have_vic_q  <= have_vic_q | take_vic;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    beat_idx_q <= issue_idx_i;
    if (take_match) begin
      match_idx_q   <= beat_idx_q;
      match_value_q <= rd_data_i.value;
      match_count_q <= rd_data_i.count;
    end
    if (take_free) begin
      free_idx_q <= beat_idx_q;
    end
    if (take_vic) begin
      vic_idx_q   <= beat_idx_q;
      vic_key_q   <= rd_data_i.key;
      vic_count_q <= rd_data_i.count;
      vic_age_q   <= age;
    end
  end

  always_comb begin
    res_o.found       = found_q;
    res_o.match_idx   = match_idx_q;
    res_o.match_value = match_value_q;
    res_o.match_count = match_count_q;
    res_o.have_free   = have_free_q;
    res_o.free_idx    = free_idx_q;
    res_o.have_victim = have_vic_q;
    res_o.victim_idx  = vic_idx_q;
    res_o.victim_key  = vic_key_q;
  end

endmodule

>>> sv/lfu_cache_table.sv
`timescale 1ns / 1ps

// Key/value cache with least-frequently-used replacement, ties going to the
// entry touched least recently. A request word is taken at a clock edge where
// start is high and busy is low; mode selects a get or a put of lookup_key_i.
// The block then reads every entry of its table memory once, one entry per
// cycle, to find the matching key, the first free slot and the victim
// together. A drain state then takes the last read, and a write state writes
// the updated entry back. The result word appears on the result ports, marked
// by done_o for exactly one cycle, and busy falls in that same cycle, so a new
// request can be taken as the result appears but not while one is in flight.
// The scan over the single read port of the table memory sets the request
// time, growing with the entry count. The receiver cannot stall; results are
// never held back. The capacity register is written through its own channel,
// which is always ready, and must only be written while busy is low. Reset
// empties the cache, clears the recency stamp and sets the capacity to 16;
// no clearing pass is needed, so a request can be taken right after reset.
module lfu_cache_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               mode_i,
  input  logic signed [lfu_pkg::KEY_W-1:0]   lookup_key_i,
  input  logic signed [lfu_pkg::VALUE_W-1:0] write_value_i,
  output logic                               done_o,
  output logic                               hit_o,
  output logic signed [lfu_pkg::VALUE_W-1:0] read_value_o,
  output logic                               evicted_o,
  output logic signed [lfu_pkg::KEY_W-1:0]   evicted_key_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lfu_pkg::CAP_W-1:0]          cfg_data_i
);

  lfu_pkg::state_e                   state_q;
  lfu_pkg::state_e                   state_d;
  logic [lfu_pkg::IDX_W-1:0]         addr_q;
  logic [lfu_pkg::CAP_W-1:0]         capacity_q;
  logic [lfu_pkg::ENTRIES-1:0]       valid_q;
  logic [lfu_pkg::OCC_W-1:0]         occ_q;
  logic [lfu_pkg::STAMP_W-1:0]       stamp_q;
  logic                              req_mode_q;
  logic [lfu_pkg::KEY_W-1:0]         req_key_q;
  logic [lfu_pkg::VALUE_W-1:0]       req_value_q;
  logic                              done_q;
  logic                              hit_q;
  logic                              hit_d;
  logic [lfu_pkg::VALUE_W-1:0]       read_value_q;
  logic [lfu_pkg::VALUE_W-1:0]       read_value_d;
  logic                              evicted_q;
  logic                              evicted_d;
  logic [lfu_pkg::KEY_W-1:0]         evicted_key_q;
  logic [lfu_pkg::KEY_W-1:0]         evicted_key_d;

  logic                              accept;
  logic                              issue;
  logic                              wr_en;
  logic [lfu_pkg::IDX_W-1:0]         wr_addr;
  lfu_pkg::entry_t                   wr_data;
  lfu_pkg::entry_t                   rd_data;
  logic                              set_valid;
  logic                              occ_inc;
  logic [lfu_pkg::CMP_W-1:0]         cap_ext;
  logic [lfu_pkg::CMP_W-1:0]         cap_eff;
  logic [lfu_pkg::CMP_W-1:0]         occ_ext;
  logic [lfu_pkg::COUNT_BITS-1:0]    bumped;
  lfu_pkg::scan_res_t                scan;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign cap_ext = lfu_pkg::CMP_W'(capacity_q);
  assign cap_eff = (cap_ext > lfu_pkg::CMP_W'(lfu_pkg::ENTRIES)) ?
                   lfu_pkg::CMP_W'(lfu_pkg::ENTRIES) : cap_ext;
  assign occ_ext = lfu_pkg::CMP_W'(occ_q);
  assign bumped  = (scan.match_count == lfu_pkg::COUNT_MAX) ?
                   scan.match_count : scan.match_count + lfu_pkg::COUNT_INIT;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lfu_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lfu_pkg::ST_SCAN;
        end
      end
      lfu_pkg::ST_SCAN: begin
        if (addr_q == lfu_pkg::LAST_IDX) begin
          state_d = lfu_pkg::ST_DRAIN;
        end
      end
      lfu_pkg::ST_DRAIN: state_d = lfu_pkg::ST_WRITE;
      lfu_pkg::ST_WRITE: state_d = lfu_pkg::ST_IDLE;
      default:           state_d = lfu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = (state_q != lfu_pkg::ST_IDLE);
    issue = (state_q == lfu_pkg::ST_SCAN);
  end

  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = scan.match_idx;
    wr_data.key   = req_key_q;
    wr_data.value = req_value_q;
    wr_data.count = bumped;
    wr_data.stamp = stamp_q;
    set_valid     = 1'b0;
    occ_inc       = 1'b0;
    hit_d         = 1'b0;
    read_value_d  = '0;
    evicted_d     = 1'b0;
    evicted_key_d = '0;
    if (state_q == lfu_pkg::ST_WRITE) begin
      priority if (req_mode_q == lfu_pkg::MODE_GET) begin
        if (scan.found) begin
          wr_en         = 1'b1;
          wr_data.value = scan.match_value;
          hit_d         = 1'b1;
          read_value_d  = scan.match_value;
        end
      end else if (cap_eff == '0) begin
        wr_en = 1'b0;
      end else if (scan.found) begin
        wr_en = 1'b1;
        hit_d = 1'b1;
      end else if ((occ_ext >= cap_eff) && scan.have_victim) begin
        wr_en         = 1'b1;
        wr_addr       = scan.victim_idx;
        wr_data.count = lfu_pkg::COUNT_INIT;
        set_valid     = 1'b1;
        evicted_d     = 1'b1;
        evicted_key_d = scan.victim_key;
      end else if (scan.have_free) begin
        wr_en         = 1'b1;
        wr_addr       = scan.free_idx;
        wr_data.count = lfu_pkg::COUNT_INIT;
        set_valid     = 1'b1;
        occ_inc       = 1'b1;
      end else begin
        wr_en = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lfu_pkg::ST_IDLE;
      addr_q     <= '0;
      capacity_q <= lfu_pkg::CAP_RESET;
      valid_q    <= '0;
      occ_q      <= '0;
      stamp_q    <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == lfu_pkg::ST_WRITE);
      if (accept) begin
        addr_q <= '0;
      end else if (issue) begin
        addr_q <= addr_q + 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        capacity_q <= cfg_data_i;
      end
      if (set_valid) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (occ_inc) begin
        occ_q <= occ_q + 1'b1;
      end
      if (wr_en) begin
        stamp_q <= stamp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_mode_q  <= mode_i;
      req_key_q   <= lookup_key_i;
      req_value_q <= write_value_i;
    end
    if (state_q == lfu_pkg::ST_WRITE) begin
      hit_q         <= hit_d;
      read_value_q  <= read_value_d;
      evicted_q     <= evicted_d;
      evicted_key_q <= evicted_key_d;
    end
  end

  lfu_ram #(
    .WIDTH ($bits(lfu_pkg::entry_t)),
    .DEPTH (lfu_pkg::ENTRIES),
    .AW    (lfu_pkg::IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  lfu_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clr_i        (accept),
    .issue_i      (issue),
    .issue_idx_i  (addr_q),
    .valid_bits_i (valid_q),
    .rd_data_i    (rd_data),
    .key_i        (req_key_q),
    .stamp_i      (stamp_q),
    .res_o        (scan)
  );

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign read_value_o  = read_value_q;
  assign evicted_o     = evicted_q;
  assign evicted_key_o = evicted_key_q;

  a_occ_tracks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == lfu_pkg::OCC_W'($countones(valid_q)))
    else $error("occupancy differs from the number of valid entries");

  a_done_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == lfu_pkg::ST_WRITE))
    else $error("result word without a write-back cycle");

  a_evict_excl_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && evicted_o |-> !hit_o && (read_value_o == '0))
    else $error("eviction reported together with a hit");

  a_stamp_per_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> stamp_q == $past(stamp_q) + lfu_pkg::STAMP_W'(1))
    else $error("recency stamp did not advance on a table write");

  a_write_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == lfu_pkg::ST_WRITE && !issue)
    else $error("table written outside the write-back cycle");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LIMIT_CYCLES = 4_000_000;
  localparam int unsigned SAT_GETS     = 40;
  localparam int unsigned KEY_POOL     = 24;
  localparam int unsigned SEG_ITEMS    = 92;

  localparam logic [lfu_pkg::KEY_W-1:0] KEY_LOW  = 32'h8000_0000;
  localparam logic [lfu_pkg::KEY_W-1:0] KEY_HIGH = 32'h7FFF_FFFF;
  localparam logic [lfu_pkg::KEY_W-1:0] ALL_ONES = '1;
  localparam logic [lfu_pkg::KEY_W-1:0] SAT_KEY  = 32'h5A5A_0001;

  localparam logic [lfu_pkg::CAP_W-1:0] CAP_PLAN [15] = '{
    5'd16, 5'd3, 5'd31, 5'd1, 5'd8,
    5'd0, 5'd12, 5'd16, 5'd2, 5'd20,
    5'd5, 5'd31, 5'd16, 5'd7, 5'd9
  };

  typedef struct packed {
    logic                        hit;
    logic [lfu_pkg::VALUE_W-1:0] read_value;
    logic                        evicted;
    logic [lfu_pkg::KEY_W-1:0]   evicted_key;
  } cache_reply_t;

  class lfu_scoreboard;
    logic [lfu_pkg::CAP_W-1:0]      capacity;
    bit                             slot_used  [lfu_pkg::ENTRIES];
    logic [lfu_pkg::KEY_W-1:0]      slot_key   [lfu_pkg::ENTRIES];
    logic [lfu_pkg::VALUE_W-1:0]    slot_value [lfu_pkg::ENTRIES];
    logic [lfu_pkg::COUNT_BITS-1:0] slot_uses  [lfu_pkg::ENTRIES];
    logic [lfu_pkg::STAMP_W-1:0]    slot_stamp [lfu_pkg::ENTRIES];
    logic [lfu_pkg::STAMP_W-1:0]    now_stamp;
    int unsigned                    filled;
    cache_reply_t                   replies_due[$];
    int unsigned                    failures;

    function new();
      capacity = lfu_pkg::CAP_RESET;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      now_stamp = '0;
      filled    = 0;
      failures  = 0;
    endfunction

    function void touch_slot(int unsigned s);
      slot_stamp[s] = now_stamp;
      now_stamp     = now_stamp + 1'b1;
    endfunction

    function void bump_slot(int unsigned s);
      if (slot_uses[s] != lfu_pkg::COUNT_MAX) slot_uses[s] = slot_uses[s] + 1'b1;
      touch_slot(s);
    endfunction

    function void note_request(logic mode, logic [lfu_pkg::KEY_W-1:0] key,
                               logic [lfu_pkg::VALUE_W-1:0] value);
      cache_reply_t                reply;
      int unsigned                 cap, match_idx, free_idx, victim_idx, target;
      bit                          found, have_free, have_victim;
      logic [lfu_pkg::STAMP_W-1:0] age, oldest_age;
      reply       = '0;
      cap         = (capacity > lfu_pkg::ENTRIES) ? lfu_pkg::ENTRIES : capacity;
      found       = 1'b0;
      have_free   = 1'b0;
      have_victim = 1'b0;
      match_idx   = 0;
      free_idx    = 0;
      victim_idx  = 0;
      oldest_age  = '0;
      for (int unsigned i = 0; i < lfu_pkg::ENTRIES; i++) begin
        if (!slot_used[i]) begin
          if (!have_free) begin
            have_free = 1'b1;
            free_idx  = i;
          end
        end else begin
          if (!found && slot_key[i] == key) begin
            found     = 1'b1;
            match_idx = i;
          end
          age = now_stamp - slot_stamp[i];
          if (!have_victim || slot_uses[i] < slot_uses[victim_idx] ||
              (slot_uses[i] == slot_uses[victim_idx] && age > oldest_age)) begin
            have_victim = 1'b1;
            victim_idx  = i;
            oldest_age  = age;
          end
        end
      end
      if (mode == lfu_pkg::MODE_GET) begin
        if (found) begin
          reply.hit        = 1'b1;
          reply.read_value = slot_value[match_idx];
          bump_slot(match_idx);
        end
      end else if (cap != 0) begin
        if (found) begin
          reply.hit             = 1'b1;
          slot_value[match_idx] = value;
          bump_slot(match_idx);
        end else begin
          target = lfu_pkg::ENTRIES;
          if (filled >= cap && have_victim) begin
            reply.evicted     = 1'b1;
            reply.evicted_key = slot_key[victim_idx];
            target            = victim_idx;
          end else if (have_free) begin
            target = free_idx;
            filled++;
          end
          if (target < lfu_pkg::ENTRIES) begin
            slot_used[target]  = 1'b1;
            slot_key[target]   = key;
            slot_value[target] = value;
            slot_uses[target]  = lfu_pkg::COUNT_INIT;
            touch_slot(target);
          end
        end
      end
      replies_due.push_back(reply);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t ns: %s expected 'h%08h, got 'h%08h", $time, field, want, got);
      end
    endfunction

    function void check_reply(logic hit, logic [lfu_pkg::VALUE_W-1:0] read_value,
                              logic evicted, logic [lfu_pkg::KEY_W-1:0] evicted_key);
      cache_reply_t want;
      if (replies_due.size() == 0) begin
        failures++;
        $display("%0t ns: result word with no request outstanding", $time);
        return;
      end
      want = replies_due.pop_front();
      compare_field("hit", want.hit, hit);
      compare_field("read_value", want.read_value, read_value);
      compare_field("evicted", want.evicted, evicted);
      compare_field("evicted_key", want.evicted_key, evicted_key);
    endfunction
  endclass

  logic                               clk_i         = 1'b0;
  logic                               rst_ni        = 1'b0;
  logic                               start         = 1'b0;
  logic                               busy;
  logic                               mode_i        = lfu_pkg::MODE_GET;
  logic signed [lfu_pkg::KEY_W-1:0]   lookup_key_i  = '0;
  logic signed [lfu_pkg::VALUE_W-1:0] write_value_i = '0;
  logic                               done_o;
  logic                               hit_o;
  logic signed [lfu_pkg::VALUE_W-1:0] read_value_o;
  logic                               evicted_o;
  logic signed [lfu_pkg::KEY_W-1:0]   evicted_key_o;
  logic                               cfg_valid_i   = 1'b0;
  logic                               cfg_ready_o;
  logic [lfu_pkg::CAP_W-1:0]          cfg_data_i    = '0;

  lfu_scoreboard cache_model = new();
  int unsigned   sender_idle_pct = 7;
  int unsigned   cycle_count = 0;
  logic [lfu_pkg::KEY_W-1:0] key_pool [KEY_POOL];

  lfu_cache_table i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .lookup_key_i  (lookup_key_i),
    .write_value_i (write_value_i),
    .done_o        (done_o),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1)
      cache_model.check_reply(hit_o, read_value_o, evicted_o, evicted_key_o);
  end

  task automatic send_request(input logic mode, input logic [lfu_pkg::KEY_W-1:0] key,
                              input logic [lfu_pkg::VALUE_W-1:0] value);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    mode_i        <= mode;
    lookup_key_i  <= key;
    write_value_i <= value;
    do @(posedge clk_i); while (busy !== 1'b0);
    cache_model.note_request(mode, key, value);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (cache_model.replies_due.size() != 0);
  endtask

  task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] cap);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    cache_model.capacity = cap;
  endtask

  initial begin
    int unsigned               pool_span;
    logic [lfu_pkg::KEY_W-1:0] key;
    key_pool[0] = '0;
    key_pool[1] = ALL_ONES;
    key_pool[2] = KEY_LOW;
    key_pool[3] = KEY_HIGH;
    for (int unsigned i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty table, extreme keys and values, update of a present key.
    send_request(lfu_pkg::MODE_GET, '0, ALL_ONES);
    send_request(lfu_pkg::MODE_PUT, KEY_LOW, KEY_HIGH);
    send_request(lfu_pkg::MODE_PUT, KEY_HIGH, KEY_LOW);
    send_request(lfu_pkg::MODE_PUT, '0, ALL_ONES);
    send_request(lfu_pkg::MODE_GET, KEY_LOW, '0);
    send_request(lfu_pkg::MODE_GET, KEY_HIGH, '0);
    send_request(lfu_pkg::MODE_PUT, KEY_LOW, 32'd5);
    send_request(lfu_pkg::MODE_GET, ALL_ONES, '0);
    send_request(lfu_pkg::MODE_GET, '0, '0);

    // With zero capacity a put is dropped even when its key is present.
    write_capacity('0);
    send_request(lfu_pkg::MODE_PUT, KEY_HIGH, 32'd7);
    send_request(lfu_pkg::MODE_PUT, 32'd12, 32'd3);
    send_request(lfu_pkg::MODE_GET, KEY_HIGH, '0);

    // Capacity below the occupancy: inserts replace a victim.
    write_capacity(5'd2);
    send_request(lfu_pkg::MODE_PUT, 32'd100, 32'd1);
    send_request(lfu_pkg::MODE_PUT, 32'd101, 32'd2);
    send_request(lfu_pkg::MODE_GET, 32'd100, '0);

    write_capacity(5'd31);
    send_request(lfu_pkg::MODE_PUT, -32'sd5, 32'd50);
    send_request(lfu_pkg::MODE_PUT, -32'sd6, 32'd60);
    send_request(lfu_pkg::MODE_GET, -32'sd5, '0);

    write_capacity(5'd1);
    send_request(lfu_pkg::MODE_PUT, 32'd77, 32'd77);
    send_request(lfu_pkg::MODE_GET, 32'd77, '0);

    // Raise one use count well above its neighbor, then make sure it survives an insert.
    sender_idle_pct = 0;
    write_capacity(5'd2);
    send_request(lfu_pkg::MODE_PUT, SAT_KEY, 32'h1234_5678);
    send_request(lfu_pkg::MODE_PUT, SAT_KEY ^ 32'd1, 32'h0BAD_F00D);
    repeat (SAT_GETS) send_request(lfu_pkg::MODE_GET, SAT_KEY, $urandom());
    send_request(lfu_pkg::MODE_PUT, SAT_KEY ^ 32'd2, $urandom());
    send_request(lfu_pkg::MODE_GET, SAT_KEY, '0);

    for (int unsigned phase_idx = 0; phase_idx < 3; phase_idx++) begin
      sender_idle_pct = (phase_idx == 0) ? 7 : (phase_idx == 1) ? 67 : 0;
      for (int unsigned seg = 0; seg < 5; seg++) begin
        write_capacity(CAP_PLAN[phase_idx * 5 + seg]);
        pool_span = $urandom_range(4, KEY_POOL);
        repeat (SEG_ITEMS) begin
          key = ($urandom_range(99) < 90) ? key_pool[$urandom_range(pool_span - 1)]
                                          : $urandom();
          send_request(($urandom_range(99) < 45) ? lfu_pkg::MODE_PUT : lfu_pkg::MODE_GET,
                       key, $urandom());
        end
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (cache_model.failures == 0 && cache_model.replies_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
